FILE: design/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Types and constants shared by the I2C byte master engine.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  // Command codes carried by an input word
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Delay register reset value, in ticks
  localparam logic [15:0] DELAY_RESET = 16'd40;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST1     = 4'd1,
    PH_ST2     = 4'd2,
    PH_SP1     = 4'd3,
    PH_SP2     = 4'd4,
    PH_SP3     = 4'd5,
    PH_WR_LOW  = 4'd6,
    PH_WR_HIGH = 4'd7,
    PH_RD_LOW  = 4'd8,
    PH_RD_HIGH = 4'd9
  } phase_t;

  // Input word: one bus tick
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } i2cbm_in_t;

  // Result word: line controls and status for one tick
  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       acked;
    logic [7:0] rx_byte;
  } i2cbm_out_t;

  // Engine state carried from tick to tick
  typedef struct packed {
    phase_t     phase;
    logic [2:0] active_command;
    logic [3:0] bit_index;
    logic [15:0] wait_count;
    logic [7:0] shift_data;
    logic       scl_level;
    logic       sda_level;
    logic       ack_flag;
    logic       nack_flag;
  } i2cbm_state_t;

endpackage

FILE: design/i2c_byte_master.sv
// ----------------------------------------------------------------------------
// i2c_byte_master
// Open-drain I2C master byte engine, one bus tick per input word.
// ----------------------------------------------------------------------------
// Each input word is one tick: it carries the sampled SDA level and an
// optional command (start, stop, write byte, read byte). Every accepted word
// yields exactly one result word with the SCL/SDA release controls, busy,
// a done pulse, and the ACK or received byte on the done tick. Words are
// taken at one per cycle while in_ready is high: the next state is computed
// from the state registers and the incoming word and lands in an output
// register, which is refilled in the same cycle it is drained. cfg_wr_data
// sets the delay in ticks between line changes (0 acts as 1); write it only
// while idle. Commands that arrive while a sequence is running are ignored.
// ----------------------------------------------------------------------------
module i2c_byte_master (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cbm_pkg::i2cbm_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cbm_pkg::i2cbm_out_t out_data,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data
);
  import i2cbm_pkg::*;

  logic [15:0]  delay_r;
  logic [15:0]  dly_load;
  i2cbm_state_t state_r;
  i2cbm_state_t state_nxt;
  i2cbm_out_t   res_nxt;
  i2cbm_out_t   out_data_r;
  logic         out_valid_r;
  logic         in_fire;

  // Delay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_wr_en) begin
      delay_r <= cfg_wr_data;
    end
  end

  // Countdown reload value; zero delay behaves as one tick
  assign dly_load = (delay_r == 16'd0) ? 16'd0 : delay_r - 16'd1;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  i2cbm_step u_step (
    .state_i    (state_r),
    .item_i     (in_data),
    .dly_load_i (dly_load),
    .state_o    (state_nxt),
    .res_o      (res_nxt)
  );

  // Engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase          <= PH_IDLE;
      state_r.active_command <= CMD_NONE;
      state_r.bit_index      <= 4'd0;
      state_r.wait_count     <= 16'd0;
      state_r.shift_data     <= 8'd0;
      state_r.scl_level      <= 1'b1;
      state_r.sda_level      <= 1'b1;
      state_r.ack_flag       <= 1'b0;
      state_r.nack_flag      <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A done word never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done with busy set");

  // ACK and received byte show only on a done word
  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.acked || (out_data_r.rx_byte != 8'd0))
      |-> out_data_r.done_res)
    else $error("status outside done");

  // A start command taken while idle enters the first start phase
  a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (state_r.phase == PH_IDLE) && (in_data.command == CMD_START)
      |=> (state_r.phase == PH_ST1) && out_data_r.busy_res)
    else $error("start not taken");

  // Every accepted word leaves a result behind
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("result lost");

  // Busy in the result mirrors the phase register
  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_data_r.busy_res == (state_r.phase != PH_IDLE)))
    else $error("busy mismatch");

endmodule

FILE: design/i2cbm_step.sv
// ----------------------------------------------------------------------------
// i2cbm_step
// Next-state and result logic for one bus tick of the I2C byte master.
// ----------------------------------------------------------------------------
module i2cbm_step (
  input  i2cbm_pkg::i2cbm_state_t state_i,
  input  i2cbm_pkg::i2cbm_in_t    item_i,
  input  logic [15:0]             dly_load_i,
  output i2cbm_pkg::i2cbm_state_t state_o,
  output i2cbm_pkg::i2cbm_out_t   res_o
);
  import i2cbm_pkg::*;

  i2cbm_state_t nxt;
  logic         done;
  logic [3:0]   bit_inc;

  assign bit_inc = state_i.bit_index + 4'd1;

  // Sequencer: accept when idle, count down a delay, or take the next step
  always_comb begin
    nxt  = state_i;
    done = 1'b0;
    if (state_i.phase == PH_IDLE) begin
      nxt.active_command = item_i.command;
      unique case (item_i.command)
        CMD_START: begin
          nxt.sda_level  = 1'b1;
          nxt.scl_level  = 1'b1;
          nxt.wait_count = dly_load_i;
          nxt.phase      = PH_ST1;
        end
        CMD_STOP: begin
          nxt.sda_level  = 1'b0;
          nxt.wait_count = dly_load_i;
          nxt.phase      = PH_SP1;
        end
        CMD_WRITE: begin
          nxt.shift_data = item_i.tx_byte;
          nxt.bit_index  = 4'd0;
          nxt.sda_level  = item_i.tx_byte[7];
          nxt.wait_count = dly_load_i;
          nxt.phase      = PH_WR_LOW;
        end
        CMD_READ: begin
          nxt.shift_data = 8'd0;
          nxt.bit_index  = 4'd0;
          nxt.nack_flag  = item_i.send_nack;
          nxt.sda_level  = 1'b1;
          nxt.wait_count = dly_load_i;
          nxt.phase      = PH_RD_LOW;
        end
        default: nxt.active_command = CMD_NONE;
      endcase
    end else if (state_i.wait_count != 16'd0) begin
      nxt.wait_count = state_i.wait_count - 16'd1;
    end else begin
      unique case (state_i.phase)
        PH_ST1: begin
          nxt.sda_level  = 1'b0;
          nxt.wait_count = dly_load_i;
          nxt.phase      = PH_ST2;
        end
        PH_ST2: begin
          nxt.scl_level = 1'b0;
          nxt.phase     = PH_IDLE;
          done          = 1'b1;
        end
        PH_SP1: begin
          nxt.scl_level  = 1'b1;
          nxt.wait_count = dly_load_i;
          nxt.phase      = PH_SP2;
        end
        PH_SP2: begin
          nxt.sda_level  = 1'b1;
          nxt.wait_count = dly_load_i;
          nxt.phase      = PH_SP3;
        end
        PH_SP3: begin
          nxt.phase = PH_IDLE;
          done      = 1'b1;
        end
        PH_WR_LOW: begin
          nxt.scl_level  = 1'b1;
          nxt.wait_count = dly_load_i;
          nxt.phase      = PH_WR_HIGH;
        end
        PH_RD_LOW: begin
          nxt.scl_level  = 1'b1;
          nxt.wait_count = dly_load_i;
          nxt.phase      = PH_RD_HIGH;
        end
        PH_WR_HIGH: begin
          nxt.scl_level = 1'b0;
          if (state_i.bit_index[3]) begin
            // ninth clock: sample the slave's ACK
            nxt.ack_flag = ~item_i.sda_in;
            nxt.phase    = PH_IDLE;
            done         = 1'b1;
          end else begin
            nxt.bit_index  = bit_inc;
            // MSB first; release SDA for the ACK slot
            nxt.sda_level  = bit_inc[3] ? 1'b1 : state_i.shift_data[~bit_inc[2:0]];
            nxt.wait_count = dly_load_i;
            nxt.phase      = PH_WR_LOW;
          end
        end
        PH_RD_HIGH: begin
          nxt.scl_level = 1'b0;
          if (state_i.bit_index[3]) begin
            nxt.sda_level = 1'b1;
            nxt.phase     = PH_IDLE;
            done          = 1'b1;
          end else begin
            nxt.shift_data = {state_i.shift_data[6:0], item_i.sda_in};
            nxt.bit_index  = bit_inc;
            if (bit_inc[3]) begin
              nxt.sda_level = state_i.nack_flag;
            end
            nxt.wait_count = dly_load_i;
            nxt.phase      = PH_RD_LOW;
          end
        end
        default: nxt.phase = PH_IDLE;
      endcase
    end
  end

  assign state_o = nxt;

  // Result word for this tick
  always_comb begin
    res_o.scl_release = nxt.scl_level;
    res_o.sda_release = nxt.sda_level;
    res_o.busy_res    = (nxt.phase != PH_IDLE);
    res_o.done_res    = done;
    res_o.acked       = done && (nxt.active_command == CMD_WRITE) && nxt.ack_flag;
    res_o.rx_byte     = (done && (nxt.active_command == CMD_READ)) ? nxt.shift_data : 8'd0;
  end

endmodule

FILE: tb/tb_i2c_byte_master.sv
// ----------------------------------------------------------------------------
// tb_i2c_byte_master
// Self-checking testbench for the I2C byte master engine.
// ----------------------------------------------------------------------------
// A scheduler fills a queue of bus-tick words: a start condition at the reset
// delay, directed write, read and stop sequences at a short delay, then
// random transactions under several delay settings, among them 0 and 2.
// A clocked driver offers the words in random bursts. A cycle-accurate
// predictor runs on every accepted word, and a clocked monitor compares each
// result word with the oldest prediction while stalling out_ready on its own
// pattern.
// ----------------------------------------------------------------------------
module tb_i2c_byte_master;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbm_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOW_LIMIT   = 10;
  localparam int HOLD_AT      = 350;   // result count that triggers the long hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;

  // SDA stimulus styles
  localparam int SDA_RANDOM = 0;
  localparam int SDA_LOW    = 1;
  localparam int SDA_PULLUP = 2;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  i2cbm_in_t   in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  i2cbm_out_t  out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  i2c_byte_master uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // Words waiting to be driven, and predicted result words
  i2cbm_in_t    pend_words[$];
  i2cbm_out_t   want_words[$];

  // Predictor state (driver side) and scheduling state (generator side)
  i2cbm_state_t engine_st;
  logic [15:0]  engine_dly = DELAY_RESET;
  i2cbm_state_t sched_st;
  logic [15:0]  sched_dly  = DELAY_RESET;
  int           words_planned = 0;

  int fail_count = 0;
  int n_results  = 0;
  int cycle_cnt  = 0;

  function automatic i2cbm_state_t idle_state();
    i2cbm_state_t s;
    s           = '0;
    s.phase     = PH_IDLE;
    s.scl_level = 1'b1;
    s.sda_level = 1'b1;
    return s;
  endfunction

  // One bus tick of the engine: updates the state, returns the result word
  function automatic i2cbm_out_t bus_tick(inout i2cbm_state_t s, input logic [15:0] dly,
                                          input i2cbm_in_t w);
    logic [15:0] reload;
    logic        done;
    i2cbm_out_t  r;
    reload = (dly == 16'd0) ? 16'd0 : dly - 16'd1;
    done   = 1'b0;
    if (s.phase == PH_IDLE) begin
      s.active_command = w.command;
      case (w.command)
        CMD_START: begin
          s.sda_level  = 1'b1;
          s.scl_level  = 1'b1;
          s.wait_count = reload;
          s.phase      = PH_ST1;
        end
        CMD_STOP: begin
          s.sda_level  = 1'b0;
          s.wait_count = reload;
          s.phase      = PH_SP1;
        end
        CMD_WRITE: begin
          s.shift_data = w.tx_byte;
          s.bit_index  = 4'd0;
          s.sda_level  = w.tx_byte[7];
          s.wait_count = reload;
          s.phase      = PH_WR_LOW;
        end
        CMD_READ: begin
          s.shift_data = 8'd0;
          s.bit_index  = 4'd0;
          s.nack_flag  = w.send_nack;
          s.sda_level  = 1'b1;
          s.wait_count = reload;
          s.phase      = PH_RD_LOW;
        end
        default: s.active_command = CMD_NONE;
      endcase
    end else if (s.wait_count != 16'd0) begin
      s.wait_count = s.wait_count - 16'd1;
    end else begin
      case (s.phase)
        PH_ST1: begin
          s.sda_level  = 1'b0;
          s.wait_count = reload;
          s.phase      = PH_ST2;
        end
        PH_ST2: begin
          s.scl_level = 1'b0;
          s.phase     = PH_IDLE;
          done        = 1'b1;
        end
        PH_SP1: begin
          s.scl_level  = 1'b1;
          s.wait_count = reload;
          s.phase      = PH_SP2;
        end
        PH_SP2: begin
          s.sda_level  = 1'b1;
          s.wait_count = reload;
          s.phase      = PH_SP3;
        end
        PH_SP3: begin
          s.phase = PH_IDLE;
          done    = 1'b1;
        end
        PH_WR_LOW: begin
          s.scl_level  = 1'b1;
          s.wait_count = reload;
          s.phase      = PH_WR_HIGH;
        end
        PH_RD_LOW: begin
          s.scl_level  = 1'b1;
          s.wait_count = reload;
          s.phase      = PH_RD_HIGH;
        end
        PH_WR_HIGH: begin
          s.scl_level = 1'b0;
          if (s.bit_index >= 4'd8) begin
            // ninth SCL high: slave ACK is SDA low
            s.ack_flag = ~w.sda_in;
            s.phase    = PH_IDLE;
            done       = 1'b1;
          end else begin
            s.bit_index  = s.bit_index + 4'd1;
            s.sda_level  = (s.bit_index < 4'd8) ? s.shift_data[3'd7 - s.bit_index[2:0]] : 1'b1;
            s.wait_count = reload;
            s.phase      = PH_WR_LOW;
          end
        end
        PH_RD_HIGH: begin
          s.scl_level = 1'b0;
          if (s.bit_index >= 4'd8) begin
            s.sda_level = 1'b1;
            s.phase     = PH_IDLE;
            done        = 1'b1;
          end else begin
            s.shift_data = {s.shift_data[6:0], w.sda_in};
            s.bit_index  = s.bit_index + 4'd1;
            if (s.bit_index == 4'd8) s.sda_level = s.nack_flag;
            s.wait_count = reload;
            s.phase      = PH_RD_LOW;
          end
        end
        default: s.phase = PH_IDLE;
      endcase
    end
    r.scl_release = s.scl_level;
    r.sda_release = s.sda_level;
    r.busy_res    = (s.phase != PH_IDLE);
    r.done_res    = done;
    r.acked       = (done && s.active_command == CMD_WRITE) ? s.ack_flag : 1'b0;
    r.rx_byte     = (done && s.active_command == CMD_READ) ? s.shift_data : 8'd0;
    return r;
  endfunction

  function automatic logic pick_sda(input int mode);
    case (mode)
      SDA_LOW:    return 1'b0;
      SDA_PULLUP: return 1'b1;
      default:    return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue one word and track the engine phase for scheduling
  task automatic push_word(input i2cbm_in_t w);
    void'(bus_tick(sched_st, sched_dly, w));
    pend_words.push_back(w);
    words_planned++;
  endtask

  // Issue a command on an idle tick and fill ticks until the engine is idle again
  task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] tx, input logic nack,
                         input int sda_mode, input int noise_pct, input bit hit_done);
    i2cbm_in_t    w;
    i2cbm_state_t trial;
    i2cbm_out_t   r;
    w.command   = cmd;
    w.tx_byte   = tx;
    w.send_nack = nack;
    w.sda_in    = pick_sda(sda_mode);
    push_word(w);
    while (sched_st.phase != PH_IDLE) begin
      w.command   = CMD_NONE;
      w.tx_byte   = 8'($urandom_range(0, 255));
      w.send_nack = 1'($urandom_range(0, 1));
      w.sda_in    = pick_sda(sda_mode);
      // commands while busy must be ignored
      if ($urandom_range(0, 99) < noise_pct) w.command = 3'($urandom_range(0, 7));
      if (hit_done) begin
        trial = sched_st;
        r     = bus_tick(trial, sched_dly, w);
        if (r.done_res) w.command = 3'($urandom_range(1, 4));
      end
      push_word(w);
    end
  endtask

  // Idle ticks, some carrying the unused command codes
  task automatic idle_words(input int n);
    i2cbm_in_t w;
    for (int i = 0; i < n; i++) begin
      w.command   = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : CMD_NONE;
      w.tx_byte   = 8'($urandom_range(0, 255));
      w.send_nack = 1'($urandom_range(0, 1));
      w.sda_in    = 1'($urandom_range(0, 1));
      push_word(w);
    end
  endtask

  // Wait until every word is accepted and every result has come back
  task automatic wait_drained();
    @(negedge clk);
    while (pend_words.size() != 0 || in_valid || want_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_delay(input logic [15:0] v);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
    engine_dly = v;
    sched_dly  = v;
  endtask

  task automatic random_traffic(input int budget);
    int first;
    int n_wr;
    int n_rd;
    int noise;
    first = words_planned;
    noise = 8;
    while (words_planned - first < budget) begin
      if ($urandom_range(0, 4) != 0) begin
        // well-formed transaction: start, writes, optional reads, stop
        run_cmd(CMD_START, pick_byte(), 1'($urandom_range(0, 1)), SDA_RANDOM, noise,
                $urandom_range(0, 3) == 0);
        n_wr = $urandom_range(1, 3);
        for (int i = 0; i < n_wr; i++)
          run_cmd(CMD_WRITE, pick_byte(), 1'($urandom_range(0, 1)), SDA_RANDOM, noise,
                  $urandom_range(0, 3) == 0);
        n_rd = $urandom_range(0, 3);
        for (int i = 0; i < n_rd; i++)
          run_cmd(CMD_READ, pick_byte(),
                  (i == n_rd - 1) ? 1'b1 : 1'($urandom_range(0, 3) == 0),
                  SDA_RANDOM, noise, $urandom_range(0, 3) == 0);
        run_cmd(CMD_STOP, pick_byte(), 1'($urandom_range(0, 1)), SDA_RANDOM, noise,
                $urandom_range(0, 3) == 0);
      end else begin
        // stray command in any order, unknown codes included
        run_cmd(3'($urandom_range(0, 7)), pick_byte(), 1'($urandom_range(0, 1)),
                SDA_RANDOM, noise, $urandom_range(0, 1) == 0);
      end
      idle_words($urandom_range(0, 2));
    end
  endtask

  // Driver: bursts of words with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want_words.push_back(bus_tick(engine_st, engine_dly, in_data));
        void'(pend_words.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_words.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pend_words[0];
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare results, stall out_ready on its own pattern
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         rx_mode   = 0;
  int         mode_left = 0;
  int         pat_cnt   = 0;
  i2cbm_out_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (want_words.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("unexpected result word %h at cycle %0d", out_data, cycle_cnt);
        end else begin
          want = want_words.pop_front();
          if (out_data !== want) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
              $display({"mismatch word %0d (exp/act): scl %b/%b sda %b/%b busy %b/%b ",
                        "done %b/%b ack %b/%b rx %h/%h"}, n_results,
                       want.scl_release, out_data.scl_release,
                       want.sda_release, out_data.sda_release,
                       want.busy_res, out_data.busy_res,
                       want.done_res, out_data.done_res,
                       want.acked, out_data.acked,
                       want.rx_byte, out_data.rx_byte);
          end
        end
      end
      pat_cnt++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_results >= HOLD_AT) begin
        // long hold-off so the output stage fills and in_ready drops
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(64, 256);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= (pat_cnt % 3 != 0);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus schedule
  initial begin
    engine_st = idle_state();
    sched_st  = idle_state();

    // start condition at the reset delay
    idle_words(3);
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_PULLUP, 0, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed byte sequences at a short delay
    set_delay(16'd1);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 0, 1'b0);     // slave ACKs
    run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_PULLUP, 0, 1'b0);  // slave NACKs
    run_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 20, 1'b1); // commands while busy
    run_cmd(CMD_READ, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);   // master ACK
    run_cmd(CMD_READ, 8'hFF, 1'b1, SDA_PULLUP, 0, 1'b0);   // master NACK, all ones
    run_cmd(CMD_READ, 8'h3C, 1'b0, SDA_LOW, 20, 1'b1);     // all zeros
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);
    run_cmd(3'd5, 8'h12, 1'b1, SDA_RANDOM, 0, 1'b0);       // unknown codes while idle
    run_cmd(3'd7, 8'h34, 1'b0, SDA_RANDOM, 0, 1'b0);
    run_cmd(CMD_NONE, 8'hFF, 1'b1, SDA_RANDOM, 0, 1'b0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b1);   // stop with no start
    run_cmd(CMD_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 0, 1'b0);  // write then read back to back
    run_cmd(CMD_READ, 8'h00, 1'b1, SDA_RANDOM, 0, 1'b1);

    random_traffic(200);
    set_delay(16'd0);
    random_traffic(150);
    set_delay(16'd2);
    random_traffic(200);
    set_delay(16'd3);
    random_traffic(150);
    set_delay(16'($urandom_range(4, 6)));
    random_traffic(150);

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && want_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
